[hdl/two_voice_dds_note_sequencer_assert.svh]
// assertion macros for the two-voice dds note sequencer
// used by the top level only, no other dependencies
`ifndef TWO_VOICE_DDS_NOTE_SEQUENCER_ASSERT_SVH
`define TWO_VOICE_DDS_NOTE_SEQUENCER_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define TVDDS_ASSERT_NOW(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("sequencer check failed");

// condition must hold in the cycle after the trigger
`define TVDDS_ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("sequencer check failed");

`endif

[hdl/tvdds_pkg.sv]
// shared constants and types for the two-voice dds note sequencer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tvdds_pkg;

    // table geometry defaults
    localparam int TABLE_ROWS_DEF  = 256;
    localparam int REPEAT_JUMP_DEF = 64;
    localparam int ROW_WIDTH       = 48;

    // register reset values
    localparam logic [15:0] NOTE_LENGTH_RST = 16'd2200;
    localparam logic [15:0] GAP_ONE_RST     = 16'd800;
    localparam logic [15:0] GAP_TWO_RST     = 16'd200;

    // arithmetic constants
    localparam int PITCH_SCALE  = 134213;
    localparam int LCG_MUL      = 2053;
    localparam int LCG_INC      = 13849;
    localparam int NOISE_CUTOFF = 2000;
    localparam int LEVEL_ONE    = 60;
    localparam int LEVEL_TWO    = 40;

    // row markers in the voice-one word
    localparam logic signed [15:0] MARK_REPEAT = -16'sd2;
    localparam logic signed [15:0] MARK_END    = -16'sd1;

    // item kinds carried on tuser
    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_LOAD    = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_NOTE_LENGTH = 2'd0;
    localparam logic [1:0] REG_GAP_ONE     = 2'd1;
    localparam logic [1:0] REG_GAP_TWO     = 2'd2;

    // operands of the shared multiply-add unit: a * b + c, low 32 bits
    typedef struct packed {
        logic signed [16:0] a;
        logic [17:0]        b;
        logic [31:0]        c;
    } mac_op_t;

endpackage

`default_nettype wire

[hdl/two_voice_dds_note_sequencer.sv]
// top level of the two-voice dds note sequencer: sequencer, phase and noise logic
// depends on tvdds_pkg, tvdds_ram, tvdds_mac and the assertion macro header
//
// channel   dir  tdata (low bit up)                                tuser
// s_axis    in   row_address, tone_one_word, tone_two_word,        mode
//                noise_word (56 bits)
// m_axis    out  pwm_level, current_row (16 bits)                  -
// cfg_wr    in   write enable, index 0..2, 16-bit data             -
//
// one beat at a time; s_axis_tready is high only while the sequencer is idle.
// tick: phase, then emit; seed and noise steps come between when a noise byte is drawn
// (two passes through the multiplier). note end adds a fetch and a check per row read,
// then three steps. restart: a fetch, a check and the three steps. the note table has no
// clearing pass after reset. a finished sample waits in the output register; a tick
// stalls only at its own emit step while the previous sample is still untaken.
`timescale 1ns / 1ps
`default_nettype none
`include "two_voice_dds_note_sequencer_assert.svh"

module two_voice_dds_note_sequencer #(
    parameter int TABLE_ROWS  = tvdds_pkg::TABLE_ROWS_DEF,
    parameter int REPEAT_JUMP = tvdds_pkg::REPEAT_JUMP_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_wr_index,
    input  wire logic [15:0] cfg_wr_data,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,  // row_address, tone_one_word, tone_two_word, noise_word
    input  wire logic [1:0]  s_axis_tuser,  // mode
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata   // pwm_level, current_row
);

    import tvdds_pkg::*;

    localparam int AW       = $clog2(TABLE_ROWS);
    localparam int JUMP_MOD = REPEAT_JUMP % TABLE_ROWS;

    typedef enum logic [3:0] {
        S_IDLE, S_PHASE, S_SEED, S_NOISE, S_EMIT,
        S_FETCH, S_CHECK, S_STEP1, S_STEP2, S_STEP3
    } state_t;

    typedef enum logic [1:0] {
        CHK_REPEAT, CHK_END, CHK_LOAD
    } check_t;

    state_t state_reg;
    check_t check_reg;

    logic [15:0]   note_length_reg, gap_one_reg, gap_two_reg;
    logic [31:0]   phase_one_reg, phase_two_reg, step_one_reg, step_two_reg;
    logic [15:0]   tick_reg;
    logic [AW-1:0] ptr_reg, rd_addr_reg;
    logic          repeat_done_reg, restart_reg;
    logic [3:0]    noise_ctl_reg;
    logic [6:0]    noise_level_reg;
    logic [15:0]   seed_reg;
    logic          x_reg, y_reg;
    logic          m_valid_reg;
    logic [15:0]   out_data_reg;

    // ram and multiplier
    logic                 s_beat, ram_we;
    logic [ROW_WIDTH-1:0] ram_rdata;
    logic [15:0]          w_one, w_two, w_noise;
    mac_op_t              mac_op;
    logic [31:0]          mac_result;

    // tick datapath
    logic signed [17:0] lim_one, lim_two, tick_s;
    logic [31:0]        phase_one_next, phase_two_next;
    logic               x_next, noise_gate;
    logic [7:0]         tick_sh, rnd_byte, level;
    logic [15:0]        tick_inc;
    logic               out_free;

    // marker handling
    logic          is_rep, is_end;
    logic [AW-1:0] rep_target;

    function automatic logic [AW-1:0] row_inc(input logic [AW-1:0] r);
        row_inc = (r == AW'(TABLE_ROWS - 1)) ? '0 : r + AW'(1);
    endfunction

    function automatic logic [AW-1:0] row_back(input logic [AW-1:0] r);
        logic [AW:0] wide;
        wide = {1'b0, r} + (AW + 1)'(TABLE_ROWS - JUMP_MOD);
        row_back = (r >= AW'(JUMP_MOD)) ? r - AW'(JUMP_MOD) : wide[AW-1:0];
    endfunction

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_beat        = s_axis_tvalid && s_axis_tready;
    assign ram_we        = s_beat && (s_axis_tuser == MODE_LOAD)
                           && ({1'b0, s_axis_tdata[7:0]} < 9'(TABLE_ROWS));

    tvdds_ram #(
        .WIDTH (ROW_WIDTH),
        .DEPTH (TABLE_ROWS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (s_axis_tdata[AW-1:0]),
        .wr_data (s_axis_tdata[55:8]),
        .rd_addr (rd_addr_reg),
        .rd_data (ram_rdata)
    );

    assign w_one   = ram_rdata[15:0];
    assign w_two   = ram_rdata[31:16];
    assign w_noise = ram_rdata[47:32];

    tvdds_mac u_mac (
        .aclk   (aclk),
        .op     (mac_op),
        .result (mac_result)
    );

    assign rnd_byte = mac_result[7:0] + mac_result[15:8];

    always_comb begin
        mac_op = '0;
        case (state_reg)
            S_PHASE: begin
                mac_op.a = $signed({1'b0, seed_reg});
                mac_op.b = 18'(LCG_MUL);
                mac_op.c = 32'(LCG_INC);
            end
            S_SEED: begin
                mac_op.a = $signed({1'b0, note_length_reg - tick_reg});
                mac_op.b = {10'b0, rnd_byte};
            end
            S_STEP1: begin
                mac_op.a = $signed({w_one[15], w_one});
                mac_op.b = 18'(PITCH_SCALE);
            end
            S_STEP2: begin
                mac_op.a = $signed({w_two[15], w_two});
                mac_op.b = 18'(PITCH_SCALE);
            end
            default: mac_op = '0;
        endcase
    end

    // phases hold while the tick is inside the end-of-note gap
    assign lim_one = $signed({2'b00, note_length_reg}) - $signed({2'b00, gap_one_reg});
    assign lim_two = $signed({2'b00, note_length_reg}) - $signed({2'b00, gap_two_reg});
    assign tick_s  = $signed({2'b00, tick_reg});
    assign phase_one_next = (tick_s < lim_one) ? phase_one_reg + step_one_reg : phase_one_reg;
    assign phase_two_next = (tick_s < lim_two) ? phase_two_reg + step_two_reg : phase_two_reg;
    // decaying square: duty shrinks as the tick count grows
    assign x_next  = {3'b000, phase_one_next[31:25]} > tick_reg[15:6];
    assign tick_sh = {tick_reg[6:0], 1'b0};
    assign noise_gate = (tick_reg < 16'(NOISE_CUTOFF)) && !tick_sh[noise_ctl_reg[2:0]];

    assign level = (x_reg ? 8'(LEVEL_ONE) : 8'd0) + (y_reg ? 8'(LEVEL_TWO) : 8'd0)
                   + {1'b0, noise_level_reg};
    assign tick_inc = tick_reg + 16'd1;
    assign out_free = !m_valid_reg || m_axis_tready;

    assign is_rep     = (check_reg == CHK_REPEAT) && ($signed(w_one) == MARK_REPEAT);
    assign is_end     = (check_reg != CHK_LOAD) && ($signed(w_one) == MARK_END);
    assign rep_target = repeat_done_reg ? row_inc(rd_addr_reg) : row_back(rd_addr_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            note_length_reg <= NOTE_LENGTH_RST;
            gap_one_reg     <= GAP_ONE_RST;
            gap_two_reg     <= GAP_TWO_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_NOTE_LENGTH: note_length_reg <= cfg_wr_data;
                REG_GAP_ONE:     gap_one_reg     <= cfg_wr_data;
                REG_GAP_TWO:     gap_two_reg     <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            check_reg       <= CHK_REPEAT;
            phase_one_reg   <= '0;
            phase_two_reg   <= '0;
            step_one_reg    <= '0;
            step_two_reg    <= '0;
            tick_reg        <= '0;
            ptr_reg         <= '0;
            rd_addr_reg     <= '0;
            repeat_done_reg <= 1'b0;
            restart_reg     <= 1'b0;
            noise_ctl_reg   <= '0;
            noise_level_reg <= '0;
            seed_reg        <= '0;
            x_reg           <= 1'b0;
            y_reg           <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            // the emit step sets valid itself
            if (m_valid_reg && m_axis_tready && (state_reg != S_EMIT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_beat) begin
                        case (s_axis_tuser)
                            MODE_TICK: state_reg <= S_PHASE;
                            MODE_RESTART: begin
                                ptr_reg         <= '0;
                                tick_reg        <= '0;
                                repeat_done_reg <= 1'b0;
                                phase_one_reg   <= '0;
                                phase_two_reg   <= '0;
                                noise_ctl_reg   <= '0;
                                noise_level_reg <= '0;
                                restart_reg     <= 1'b1;
                                rd_addr_reg     <= '0;
                                check_reg       <= CHK_LOAD;
                                state_reg       <= S_FETCH;
                            end
                            default: ;
                        endcase
                    end
                end
                S_PHASE: begin
                    phase_one_reg <= phase_one_next;
                    phase_two_reg <= phase_two_next;
                    x_reg         <= x_next;
                    y_reg         <= phase_two_next[31];
                    if (!noise_ctl_reg[3]) begin
                        noise_level_reg <= '0;
                        state_reg       <= S_EMIT;
                    end else if (noise_gate) begin
                        state_reg <= S_SEED;
                    end else begin
                        state_reg <= S_EMIT;
                    end
                end
                S_SEED: begin
                    seed_reg  <= mac_result[15:0];
                    state_reg <= S_NOISE;
                end
                S_NOISE: begin
                    noise_level_reg <= mac_result[15:9];
                    state_reg       <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        out_data_reg <= {8'(ptr_reg), level};
                        m_valid_reg  <= 1'b1;
                        if (tick_inc == note_length_reg) begin
                            tick_reg    <= '0;
                            rd_addr_reg <= row_inc(ptr_reg);
                            restart_reg <= 1'b0;
                            check_reg   <= CHK_REPEAT;
                            state_reg   <= S_FETCH;
                        end else begin
                            tick_reg  <= tick_inc;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_FETCH: state_reg <= S_CHECK;
                S_CHECK: begin
                    if (is_rep) begin
                        rd_addr_reg     <= rep_target;
                        repeat_done_reg <= !repeat_done_reg;
                        check_reg       <= CHK_END;
                        state_reg       <= S_FETCH;
                    end else if (is_end) begin
                        // end marker wraps to row zero, which is taken as it stands
                        rd_addr_reg <= '0;
                        check_reg   <= CHK_LOAD;
                        state_reg   <= S_FETCH;
                    end else begin
                        ptr_reg   <= rd_addr_reg;
                        state_reg <= S_STEP1;
                    end
                end
                S_STEP1: begin
                    // restart leaves the noise control cleared
                    if (!restart_reg) begin
                        noise_ctl_reg <= w_noise[3:0];
                    end
                    state_reg <= S_STEP2;
                end
                S_STEP2: begin
                    // a zero word keeps the old step except on restart
                    if ($signed(w_one) > 16'sd0) begin
                        step_one_reg <= mac_result;
                    end else if (w_one[15] || restart_reg) begin
                        step_one_reg <= '0;
                    end
                    state_reg <= S_STEP3;
                end
                S_STEP3: begin
                    step_two_reg <= mac_result;
                    state_reg    <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `TVDDS_ASSERT_NOW(a_row_in_range, aclk, aresetn, 1'b1, ptr_reg <= AW'(TABLE_ROWS - 1))
    `TVDDS_ASSERT_NEXT(a_emit_holds, aclk, aresetn,
        (state_reg == S_EMIT) && m_valid_reg && !m_axis_tready, state_reg == S_EMIT)
    `TVDDS_ASSERT_NEXT(a_phase_quiet, aclk, aresetn,
        (state_reg != S_PHASE) && !(s_beat && (s_axis_tuser == MODE_RESTART)),
        $stable(phase_one_reg) && $stable(phase_two_reg))

endmodule

`default_nettype wire

[hdl/tvdds_ram.sv]
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module tvdds_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hdl/tvdds_mac.sv]
// shared multiply-add unit: registered low 32 bits of a * b + c
// depends on tvdds_pkg for the operand struct
`timescale 1ns / 1ps
`default_nettype none

module tvdds_mac (
    input  wire logic              aclk,
    input  wire tvdds_pkg::mac_op_t op,
    output logic [31:0]             result
);

    import tvdds_pkg::*;

    logic signed [35:0] prod;
    logic [31:0]        result_reg;

    assign prod = op.a * $signed({1'b0, op.b});

    always_ff @(posedge aclk) begin
        result_reg <= prod[31:0] + op.c;
    end

    assign result = result_reg;

endmodule

`default_nettype wire

[tb/two_voice_dds_note_sequencer_tb.sv]
// self-checking bench for the two-voice dds note sequencer: directed beats, random
// note tables and ticks, all scored live
// needs tvdds_pkg and the two_voice_dds_note_sequencer rtl
`timescale 1ns / 1ps

module two_voice_dds_note_sequencer_tb;
    import tvdds_pkg::*;

    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         SETTLE_WAIT  = 24;
    localparam int         CYCLE_LIMIT  = 5000000;

    typedef struct packed {
        logic [7:0] level;
        logic [7:0] row;
    } sample_t;

    typedef struct {
        logic [1:0]  mode;
        logic [55:0] data;
        bit          typed;
        sample_t     want;
    } dir_beat_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [1:0]  cfg_wr_index  = 2'd0;
    logic [15:0] cfg_wr_data   = 16'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata  = 56'd0;  // row_address, tone_one_word, tone_two_word, noise_word
    logic [1:0]  s_axis_tuser  = 2'd0;   // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // pwm_level, current_row

    // sequencer model state
    logic [15:0] note_len, gap_one_len, gap_two_len;
    logic [31:0] phase_one, phase_two, step_one, step_two;
    logic [15:0] tick_cnt;
    logic [7:0]  row_ptr;
    logic        repeat_taken;
    logic [3:0]  noise_ctl;
    logic [6:0]  noise_lvl;
    logic [15:0] lcg_seed;
    logic [15:0] tone_one_rows [256];
    logic [15:0] tone_two_rows [256];
    logic [15:0] noise_rows    [256];

    sample_t     pending_samples[$];
    dir_beat_t   directed_beats[$];
    sample_t     head_sample;
    int          err_count   = 0;
    int          cycle_count = 0;
    bit          idling_on   = 1'b1;
    logic [3:0]  stall_left  = 4'd0;

    two_voice_dds_note_sequencer u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("two_voice_dds_note_sequencer test failed");
            $finish;
        end
    end

    // result side back-pressure in bursts
    always @(posedge aclk) begin
        if (stall_left != 4'd0) begin
            stall_left    <= stall_left - 4'd1;
            m_axis_tready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 9) == 0) begin
            stall_left    <= 4'($urandom_range(0, 8));
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, field, got, want);
        err_count++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_samples.size() == 0) begin
                report_mismatch("unexpected beat, pwm_level", m_axis_tdata[7:0], 8'd0);
            end else begin
                head_sample = pending_samples.pop_front();
                if (m_axis_tdata[7:0] !== head_sample.level)
                    report_mismatch("pwm_level", m_axis_tdata[7:0], head_sample.level);
                if (m_axis_tdata[15:8] !== head_sample.row)
                    report_mismatch("current_row", m_axis_tdata[15:8], head_sample.row);
            end
        end
    end

    function automatic void load_steps(input logic [7:0] r, input bit zero_clears);
        logic signed [15:0] w1;
        logic [15:0]        w2;
        w1 = tone_one_rows[r];
        w2 = tone_two_rows[r];
        if (w1 > 0)
            step_one = {16'h0000, tone_one_rows[r]} * PITCH_SCALE;
        else if (w1 < 0 || zero_clears)
            step_one = 32'd0;
        step_two = {{16{w2[15]}}, w2} * PITCH_SCALE;
    endfunction

    function automatic void next_row();
        logic [7:0] r;
        r = row_ptr + 8'd1;
        if (tone_one_rows[r] == MARK_REPEAT) begin
            if (!repeat_taken) begin
                r = r - 8'(REPEAT_JUMP_DEF);
                repeat_taken = 1'b1;
            end else begin
                r = r + 8'd1;
                repeat_taken = 1'b0;
            end
        end
        // the landing row is only checked for the end marker
        if (tone_one_rows[r] == MARK_END)
            r = 8'd0;
        row_ptr = r;
        load_steps(r, 1'b0);
        noise_ctl = noise_rows[r][3:0];
    endfunction

    // returns 1 when the beat produces a sample
    function automatic bit predict_item(input logic [1:0] mode, input logic [55:0] data,
                                        output sample_t smp);
        logic [7:0]  addr;
        int          cnt_i, len_i, g1_i, g2_i;
        logic        x, y;
        logic [16:0] tick_sh;
        logic [7:0]  rnd;
        logic [15:0] prod;
        addr = data[7:0];
        smp  = '0;
        if (mode == MODE_LOAD) begin
            tone_one_rows[addr] = data[23:8];
            tone_two_rows[addr] = data[39:24];
            noise_rows[addr]    = data[55:40];
            return 1'b0;
        end
        if (mode == MODE_RESTART) begin
            row_ptr      = 8'd0;
            tick_cnt     = 16'd0;
            repeat_taken = 1'b0;
            phase_one    = 32'd0;
            phase_two    = 32'd0;
            noise_ctl    = 4'd0;
            noise_lvl    = 7'd0;
            load_steps(8'd0, 1'b1);
            return 1'b0;
        end
        if (mode != MODE_TICK)
            return 1'b0;

        cnt_i = tick_cnt;
        len_i = note_len;
        g1_i  = gap_one_len;
        g2_i  = gap_two_len;
        if (cnt_i < len_i - g1_i)
            phase_one = phase_one + step_one;
        if (cnt_i < len_i - g2_i)
            phase_two = phase_two + step_two;
        x = (phase_one[31:25] > tick_cnt[15:6]);
        y = phase_two[31];

        if (noise_ctl[3]) begin
            tick_sh = {tick_cnt, 1'b0};
            if (tick_cnt < NOISE_CUTOFF && !tick_sh[noise_ctl[2:0]]) begin
                lcg_seed  = 16'(lcg_seed * LCG_MUL + LCG_INC);
                rnd       = lcg_seed[7:0] + lcg_seed[15:8];
                prod      = (note_len - tick_cnt) * rnd;
                noise_lvl = prod[15:9];
            end
        end else begin
            noise_lvl = 7'd0;
        end

        smp.level = (x ? 8'(LEVEL_ONE) : 8'd0) + (y ? 8'(LEVEL_TWO) : 8'd0) + {1'b0, noise_lvl};
        smp.row   = row_ptr;

        tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt == note_len) begin
            tick_cnt = 16'd0;
            next_row();
        end
        return 1'b1;
    endfunction

    task automatic send_beat(input logic [1:0] mode, input logic [55:0] data,
                             input bit typed, input sample_t typed_smp);
        sample_t smp;
        int      gap;
        if (predict_item(mode, data, smp))
            pending_samples.push_back(typed ? typed_smp : smp);
        gap = 0;
        if (idling_on && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 9);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= data;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    task automatic send_tick();
        logic [63:0] junk;
        junk = {$urandom(), $urandom()};
        send_beat(MODE_TICK, junk[55:0], 1'b0, '0);
    endtask

    // drop valid, drain every pending sample, then let a trailing note end finish
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
    endtask

    task automatic write_config(input logic [15:0] len, input logic [15:0] g1,
                                input logic [15:0] g2);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= REG_NOTE_LENGTH;
        cfg_wr_data  <= len;
        @(posedge aclk);
        cfg_wr_index <= REG_GAP_ONE;
        cfg_wr_data  <= g1;
        @(posedge aclk);
        cfg_wr_index <= REG_GAP_TWO;
        cfg_wr_data  <= g2;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        note_len    = len;
        gap_one_len = g1;
        gap_two_len = g2;
    endtask

    // marker words are sprinkled in so the sequencer wraps and repeats
    function automatic logic [47:0] random_row();
        logic [15:0] w1, w2, wn;
        int          pick;
        pick = $urandom_range(0, 31);
        if (pick == 0)
            w1 = MARK_END;
        else if (pick < 3)
            w1 = MARK_REPEAT;
        else if (pick == 3)
            w1 = 16'h0000;
        else if (pick == 4)
            w1 = 16'h8000 | 16'($urandom_range(0, 16'h7FFF));
        else
            w1 = 16'($urandom_range(1, 16'h7FFF));
        w2 = 16'($urandom());
        wn = 16'($urandom());
        return {wn, w2, w1};
    endfunction

    function automatic void add_directed(input logic [1:0] mode, input logic [7:0] addr,
                                         input logic [15:0] w1, input logic [15:0] w2,
                                         input logic [15:0] wn, input bit typed,
                                         input logic [7:0] level, input logic [7:0] row);
        dir_beat_t db;
        db.mode  = mode;
        db.data  = {wn, w2, w1, addr};
        db.typed = typed;
        db.want  = {level, row};
        directed_beats.push_back(db);
    endfunction

    int          ph, n, pick;
    logic [15:0] len_pick, g1_pick, g2_pick;
    logic [47:0] row_bits;
    logic [63:0] junk;
    dir_beat_t   db;

    initial begin
        note_len     = NOTE_LENGTH_RST;
        gap_one_len  = GAP_ONE_RST;
        gap_two_len  = GAP_TWO_RST;
        phase_one    = 32'd0;
        phase_two    = 32'd0;
        step_one     = 32'd0;
        step_two     = 32'd0;
        tick_cnt     = 16'd0;
        row_ptr      = 8'd0;
        repeat_taken = 1'b0;
        noise_ctl    = 4'd0;
        noise_lvl    = 7'd0;
        lcg_seed     = 16'd0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // silent after reset, then extremes of every field, both step rules and markers
        add_directed(MODE_TICK,    8'd0,   16'h0000, 16'h0000, 16'h0000, 1'b1, 8'd0, 8'd0);
        add_directed(MODE_TICK,    8'hFF,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 8'd0, 8'd0);
        add_directed(MODE_UNUSED,  8'hFF,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 8'd0, 8'd0);
        add_directed(MODE_LOAD,    8'd0,   16'h7FFF, 16'h8000, 16'hFFFF, 1'b0, 8'd0, 8'd0);
        add_directed(MODE_LOAD,    8'd255, 16'hFFFF, 16'hFFFF, 16'h0008, 1'b0, 8'd0, 8'd0);
        add_directed(MODE_LOAD,    8'd1,   16'hFFFE, 16'h0001, 16'h0000, 1'b0, 8'd0, 8'd0);
        add_directed(MODE_LOAD,    8'd2,   16'h0000, 16'h0000, 16'h000F, 1'b0, 8'd0, 8'd0);
        add_directed(MODE_LOAD,    8'd128, 16'h0001, 16'h7FFF, 16'hFFF0, 1'b0, 8'd0, 8'd0);
        add_directed(MODE_RESTART, 8'd0,   16'h0000, 16'h0000, 16'h0000, 1'b0, 8'd0, 8'd0);
        for (n = 0; n < 6; n++)
            add_directed(MODE_TICK, 8'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 8'd0, 8'd0);
        // zero tone word on restart clears the voice-one step
        add_directed(MODE_LOAD,    8'd0,   16'h0000, 16'h0000, 16'h0008, 1'b0, 8'd0, 8'd0);
        add_directed(MODE_RESTART, 8'd0,   16'h0000, 16'h0000, 16'h0000, 1'b0, 8'd0, 8'd0);
        for (n = 0; n < 3; n++)
            add_directed(MODE_TICK, 8'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 8'd0, 8'd0);
        add_directed(MODE_LOAD,    8'd0,   16'h8000, 16'h0000, 16'h0007, 1'b0, 8'd0, 8'd0);
        add_directed(MODE_RESTART, 8'd0,   16'h0000, 16'h0000, 16'h0000, 1'b0, 8'd0, 8'd0);
        add_directed(MODE_TICK,    8'd0,   16'h0000, 16'h0000, 16'h0000, 1'b1, 8'd0, 8'd0);
        add_directed(MODE_TICK,    8'd0,   16'h0000, 16'h0000, 16'h0000, 1'b1, 8'd0, 8'd0);

        foreach (directed_beats[i]) begin
            db = directed_beats[i];
            send_beat(db.mode, db.data, db.typed, db.want);
        end

        // fill the whole note table before any note can end
        for (n = 0; n < 256; n++) begin
            row_bits = random_row();
            send_beat(MODE_LOAD, {row_bits, n[7:0]}, 1'b0, '0);
        end

        for (ph = 0; ph < 7; ph++) begin
            len_pick = 16'($urandom_range(2, 24));
            g1_pick  = 16'($urandom_range(0, len_pick));
            g2_pick  = 16'($urandom_range(0, len_pick + 4));
            case (ph)
                0: begin
                    len_pick = 16'd1;
                    g1_pick  = 16'd0;
                    g2_pick  = 16'd0;
                end
                1: begin
                    len_pick = 16'hFFFF;
                    g1_pick  = 16'hFFFF;
                    g2_pick  = 16'd0;
                end
                4: begin
                    g1_pick = 16'd0;
                    g2_pick = 16'hFFFF;
                end
                default: ;
            endcase
            settle();
            // the fourth and the last parts run without any idling
            idling_on = (ph != 3) && (ph != 6);
            write_config(len_pick, g1_pick, g2_pick);
            junk = {$urandom(), $urandom()};
            send_beat(MODE_RESTART, junk[55:0], 1'b0, '0);
            for (n = 0; n < 100; n++) begin
                if (ph == 2 && n == 50)
                    settle();
                pick = $urandom_range(0, 99);
                junk = {$urandom(), $urandom()};
                if (pick < 80) begin
                    send_tick();
                end else if (pick < 90) begin
                    row_bits = random_row();
                    send_beat(MODE_LOAD, {row_bits, junk[7:0]}, 1'b0, '0);
                end else if (pick < 96) begin
                    send_beat(MODE_RESTART, junk[55:0], 1'b0, '0);
                end else begin
                    send_beat(MODE_UNUSED, junk[55:0], 1'b0, '0);
                end
            end
        end

        settle();
        if (err_count == 0)
            $display("two_voice_dds_note_sequencer test passed");
        else
            $display("two_voice_dds_note_sequencer test failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/tvdds_pkg.sv
hdl/tvdds_ram.sv
hdl/tvdds_mac.sv
hdl/two_voice_dds_note_sequencer.sv
tb/two_voice_dds_note_sequencer_tb.sv
